[design/i2c_target_byte_echo_assert.svh]
// Assertion macros for the I2C target byte echo block.
`ifndef I2C_TARGET_BYTE_ECHO_ASSERT_SVH
`define I2C_TARGET_BYTE_ECHO_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising clock edge outside reset.
`define I2CTE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define I2CTE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`else

`define I2CTE_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define I2CTE_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[design/i2cte_pkg.sv]
// Types and constants for the I2C target byte echo block.
package i2cte_pkg;

   localparam int unsigned ADDR_WIDTH = 7;
   localparam int unsigned BYTE_WIDTH = 8;
   localparam int unsigned BIT_POS_WIDTH = 3;

   localparam logic [ADDR_WIDTH-1:0]    RESET_ADDRESS = 7'h50;
   localparam logic [BYTE_WIDTH-1:0]    RESET_BYTE    = 8'hA5;
   localparam logic [BIT_POS_WIDTH-1:0] FIRST_BIT     = 3'd7;
   localparam logic [BIT_POS_WIDTH-1:0] LAST_BIT      = 3'd0;

   // Protocol state of the target, updated once per line sample.
   typedef struct packed {
      logic                     transfer_active;
      logic                     in_address_phase;
      logic                     reading;
      logic                     in_ack_slot;
      logic [BIT_POS_WIDTH-1:0] bit_position;
      logic [BYTE_WIDTH-1:0]    shift_in;
      logic [BYTE_WIDTH-1:0]    stored_byte;
      logic [BYTE_WIDTH-1:0]    send_byte;
      logic                     pull_low;
      logic                     last_scl;
      logic                     last_sda;
   } target_state_type;

   localparam target_state_type RESET_STATE = '{
      transfer_active:  1'b0,
      in_address_phase: 1'b1,
      reading:          1'b0,
      in_ack_slot:      1'b0,
      bit_position:     FIRST_BIT,
      shift_in:         '0,
      stored_byte:      RESET_BYTE,
      send_byte:        RESET_BYTE,
      pull_low:         1'b0,
      last_scl:         1'b1,
      last_sda:         1'b1
   };

endpackage

[design/i2c_target_byte_echo.sv]
// Top level of the I2C target byte echo block: line sample in, SDA drive out.
//
//   channel   direction   handshake            payload
//   req       in          req_valid/req_ready  req_scl_level, req_sda_level
//   rsp       out         rsp_valid/rsp_ready  rsp_sda_pull_low
//   csr       in          csr_write_enable     csr_write_data (own address)
//
// One sample per cycle while req_ready is high; SDA drive shows the next cycle.
// The state update and the output register sit behind a single level of logic.
// Reset is synchronous and returns the target to idle with address 0x50.
// A stalled response blocks new samples only while the output register is full.
`include "i2c_target_byte_echo_assert.svh"

module i2c_target_byte_echo (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_scl_level,
   input  logic                            req_sda_level,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_sda_pull_low,
   input  logic                            csr_write_enable,
   input  logic [i2cte_pkg::ADDR_WIDTH-1:0] csr_write_data
);
   import i2cte_pkg::*;

   target_state_type        state_ff;
   target_state_type        state_in;
   logic [ADDR_WIDTH-1:0]   own_address_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic                    rsp_data_ff;
   logic                    req_accept;

   // Accept a word whenever the output register is empty or being drained
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   // Hold the own address register
   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff <= RESET_ADDRESS;
      end else if (csr_write_enable) begin
         own_address_ff <= csr_write_data;
      end
   end

   // Compute the protocol state after one line sample
   always_comb begin
      logic scl;
      logic sda;
      logic rise;
      logic fall;
      target_state_type s;
      scl = req_scl_level;
      sda = req_sda_level;
      s   = state_ff;

      // START: restart the address phase and release the line
      if (s.last_sda && !sda && scl) begin
         s.transfer_active  = 1'b1;
         s.in_address_phase = 1'b1;
         s.reading          = 1'b0;
         s.in_ack_slot      = 1'b0;
         s.bit_position     = FIRST_BIT;
         s.shift_in         = '0;
         s.pull_low         = 1'b0;
      end
      // STOP: end the transfer and release the line
      if (!s.last_sda && sda && scl) begin
         s.transfer_active = 1'b0;
         s.in_ack_slot     = 1'b0;
         s.pull_low        = 1'b0;
      end

      rise = !s.last_scl && scl;
      fall = s.last_scl && !scl;

      if (s.transfer_active) begin
         if (s.reading) begin
            // Drive the next data bit on a falling edge
            if (fall && !s.in_ack_slot) begin
               s.pull_low = !s.send_byte[s.bit_position];
            end
            if (rise) begin
               if (!s.in_ack_slot) begin
                  if (s.bit_position == LAST_BIT) begin
                     s.in_ack_slot = 1'b1;
                     s.pull_low    = 1'b0;
                  end else begin
                     s.bit_position = s.bit_position - 1'b1;
                  end
               end else begin
                  // Sample the master's ACK; NACK ends the read
                  s.in_ack_slot  = 1'b0;
                  s.bit_position = FIRST_BIT;
                  if (sda) begin
                     s.transfer_active = 1'b0;
                  end
               end
            end
         end else if (rise) begin
            if (s.in_ack_slot) begin
               // Release after our ACK clock
               s.in_ack_slot = 1'b0;
               s.pull_low    = 1'b0;
            end else begin
               s.shift_in = {s.shift_in[BYTE_WIDTH-2:0], sda};
               if (s.bit_position != LAST_BIT) begin
                  s.bit_position = s.bit_position - 1'b1;
               end else begin
                  s.in_ack_slot = 1'b1;
                  s.pull_low    = 1'b1;
                  if (s.in_address_phase) begin
                     // Match the address; read direction loads the send byte
                     s.reading          = s.shift_in[0];
                     s.in_address_phase = 1'b0;
                     if (s.shift_in[BYTE_WIDTH-1:1] != own_address_ff) begin
                        s.pull_low        = 1'b0;
                        s.transfer_active = 1'b0;
                     end else if (s.shift_in[0]) begin
                        s.send_byte = s.stored_byte;
                     end
                  end else begin
                     // Store the written data byte
                     s.stored_byte = s.shift_in;
                     s.send_byte   = s.shift_in;
                  end
                  s.bit_position = FIRST_BIT;
                  s.shift_in     = '0;
               end
            end
         end
      end

      s.last_scl = scl;
      s.last_sda = sda;
      state_in   = s;
   end

   // Advance the protocol state on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RESET_STATE;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   // Track the output register occupancy
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the response word
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= state_in.pull_low;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sda_pull_low = rsp_data_ff;

   `I2CTE_ASSERT_NEXT(a_accept_fills_rsp, clock, reset, req_accept, rsp_valid_ff)
   `I2CTE_ASSERT_IMPLY(a_stall_blocks_req, clock, reset, rsp_valid_ff && !rsp_ready, !req_ready)
   `I2CTE_ASSERT_IMPLY(a_idle_releases_sda, clock, reset, !state_ff.transfer_active, !state_ff.pull_low)

endmodule
